[rtl/hepm_pkg.sv]
// shared types and constants for the hall edge period meter
`timescale 1ns / 1ps
`default_nettype none

package hepm_pkg;

	localparam int TS_W  = 32;
	localparam int RES_W = 16;
	localparam int CNT_W = 8;

	// edge count after reset, so the first result counts as zero or one
	localparam logic [CNT_W-1:0] CNT_RESET = 8'hFF;

	// reciprocal constants, exact for every 32-bit dividend
	localparam logic [TS_W-1:0] DIV_TENTH_MUL   = 32'h51EB851F;
	localparam int              DIV_TENTH_SHIFT = 37;
	localparam logic [TS_W-1:0] DIV_MS_MUL      = 32'h10624DD3;
	localparam int              DIV_MS_SHIFT    = 38;

	// smallest dividends whose quotient no longer fits in 16 bits
	localparam logic [TS_W-1:0] TENTH_SAT_MIN = 32'd6553600;
	localparam logic [TS_W-1:0] MS_SAT_MIN    = 32'd65536000;
	localparam logic [RES_W-1:0] RES_SAT      = 16'hFFFF;

	typedef struct packed {
		logic [TS_W-1:0]  dt;
		logic [TS_W-1:0]  sum;
		logic             rev_valid;
		logic [CNT_W-1:0] cnt;
	} scale_in_t;

endpackage

`default_nettype wire

[rtl/hepm_ring.sv]
// interval ring memory with prefetched read of the slot to be replaced
`timescale 1ns / 1ps
`default_nettype none

module hepm_ring #(
	parameter int DEPTH = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire logic [hepm_pkg::TS_W-1:0] push_data,
	output logic      [hepm_pkg::TS_W-1:0] old_data
);

	localparam int PTR_W = $clog2(DEPTH);

	logic [hepm_pkg::TS_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]          vld_q;
	logic [PTR_W-1:0]          ptr_q;
	logic [PTR_W-1:0]          ptr_nxt;
	logic [hepm_pkg::TS_W-1:0] rd_data_q;
	logic                      rd_vld_q;

	assign ptr_nxt  = (ptr_q == PTR_W'(DEPTH - 1)) ? '0 : ptr_q + 1'b1;
	assign old_data = rd_vld_q ? rd_data_q : '0;

	// data array and prefetch of the next slot
	always_ff @(posedge clk) begin
		if (push) begin
			mem[ptr_q] <= push_data;
			rd_data_q  <= mem[ptr_nxt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			ptr_q    <= '0;
			rd_vld_q <= 1'b0;
		end else if (push) begin
			vld_q[ptr_q] <= 1'b1;
			ptr_q        <= ptr_nxt;
			rd_vld_q     <= vld_q[ptr_nxt];
		end
	end

endmodule

`default_nettype wire

[rtl/hepm_scale.sv]
// reciprocal scaling and saturation of interval and window sum
`timescale 1ns / 1ps
`default_nettype none

module hepm_scale (
	input  wire hepm_pkg::scale_in_t         sc,
	output logic [hepm_pkg::RES_W-1:0]       delta_tenth,
	output logic [hepm_pkg::RES_W-1:0]       rev_ms
);

	logic [2*hepm_pkg::TS_W-1:0] prod_tenth;
	logic [2*hepm_pkg::TS_W-1:0] prod_ms;
	logic                        sat_tenth;
	logic                        sat_ms;

	assign prod_tenth = (2*hepm_pkg::TS_W)'(sc.dt) * (2*hepm_pkg::TS_W)'(hepm_pkg::DIV_TENTH_MUL);
	assign prod_ms    = (2*hepm_pkg::TS_W)'(sc.sum) * (2*hepm_pkg::TS_W)'(hepm_pkg::DIV_MS_MUL);
	assign sat_tenth  = sc.dt >= hepm_pkg::TENTH_SAT_MIN;
	assign sat_ms     = sc.sum >= hepm_pkg::MS_SAT_MIN;

	always_comb begin
		delta_tenth = sat_tenth ? hepm_pkg::RES_SAT
			: prod_tenth[hepm_pkg::DIV_TENTH_SHIFT +: hepm_pkg::RES_W];
		if (!sc.rev_valid) begin
			rev_ms = '0;
		end else begin
			rev_ms = sat_ms ? hepm_pkg::RES_SAT
				: prod_ms[hepm_pkg::DIV_MS_SHIFT +: hepm_pkg::RES_W];
		end
	end

endmodule

`default_nettype wire

[rtl/hall_edge_period_meter.sv]
// hall edge period meter top level
// an accepted edge passes the stage one input register, stage two and the output register before its result shows
// throughput: one edge per cycle while out_ready keeps the output flowing; the running state is updated in stage one
// the first edge after reset only stores its timestamp and yields no result
// reset clears the pipeline, edge count (to 255), window sum and ring valid bits at once
`timescale 1ns / 1ps
`default_nettype none

module hall_edge_period_meter #(
	parameter int WINDOW_DEPTH = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [hepm_pkg::TS_W-1:0]    timestamp_us,
	input  wire logic                         pin_level,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [hepm_pkg::RES_W-1:0]   delta_tenth_ms,
	output logic      [hepm_pkg::CNT_W-1:0]   pulse_count,
	output logic                              rev_valid,
	output logic      [hepm_pkg::RES_W-1:0]   rev_time_ms
);

	// stage one input register
	logic                        v1_q;
	logic [hepm_pkg::TS_W-1:0]   ts_s1;
	logic                        lvl_s1;

	// running state
	logic                        have_prev_q;
	logic [hepm_pkg::TS_W-1:0]   last_ts_q;
	logic [hepm_pkg::CNT_W-1:0]  count_q;
	logic [hepm_pkg::TS_W-1:0]   sum_q;

	// stage two
	logic                        v2_q;
	hepm_pkg::scale_in_t         sc_s2;

	// output register
	logic                        out_valid_q;
	logic [hepm_pkg::RES_W-1:0]  delta_q;
	logic [hepm_pkg::CNT_W-1:0]  cnt_q;
	logic                        rev_valid_q;
	logic [hepm_pkg::RES_W-1:0]  rev_ms_q;

	logic                        out_free;
	logic                        s2_free;
	logic                        fire1;
	logic                        push;
	logic [hepm_pkg::TS_W-1:0]   dt;
	logic [hepm_pkg::TS_W-1:0]   old_dt;
	logic [hepm_pkg::TS_W-1:0]   sum_nxt;
	logic [hepm_pkg::CNT_W-1:0]  cnt_nxt;
	logic [hepm_pkg::RES_W-1:0]  delta_nxt;
	logic [hepm_pkg::RES_W-1:0]  rev_ms_nxt;

	assign out_free = !out_valid_q || out_ready;
	assign s2_free  = !v2_q || out_free;
	assign fire1    = v1_q && (!have_prev_q || s2_free);
	assign push     = fire1 && have_prev_q;
	assign in_ready = !v1_q || fire1;

	assign dt      = ts_s1 - last_ts_q;
	assign sum_nxt = sum_q - old_dt + dt;
	// one step, plus one more when parity disagrees with the level
	assign cnt_nxt = count_q + ((lvl_s1 == count_q[0]) ? hepm_pkg::CNT_W'(2)
		: hepm_pkg::CNT_W'(1));

	hepm_ring #(
		.DEPTH(WINDOW_DEPTH)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(dt),
		.old_data (old_dt)
	);

	hepm_scale u_scale (
		.sc         (sc_s2),
		.delta_tenth(delta_nxt),
		.rev_ms     (rev_ms_nxt)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ts_s1  <= timestamp_us;
			lvl_s1 <= pin_level;
		end
		if (push) begin
			sc_s2.dt        <= dt;
			sc_s2.sum       <= sum_nxt;
			sc_s2.rev_valid <= (old_dt != '0);
			sc_s2.cnt       <= cnt_nxt;
		end
		if (out_free && v2_q) begin
			delta_q     <= delta_nxt;
			cnt_q       <= sc_s2.cnt;
			rev_valid_q <= sc_s2.rev_valid;
			rev_ms_q    <= rev_ms_nxt;
		end
	end

	// control and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
			have_prev_q <= 1'b0;
			last_ts_q   <= '0;
			count_q     <= hepm_pkg::CNT_RESET;
			sum_q       <= '0;
		end else begin
			if (in_ready) begin
				v1_q <= in_valid;
			end
			if (s2_free) begin
				v2_q <= push;
			end
			if (out_free) begin
				out_valid_q <= v2_q;
			end
			if (fire1) begin
				have_prev_q <= 1'b1;
				last_ts_q   <= ts_s1;
			end
			if (push) begin
				count_q <= cnt_nxt;
				sum_q   <= sum_nxt;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign delta_tenth_ms = delta_q;
	assign pulse_count    = cnt_q;
	assign rev_valid      = rev_valid_q;
	assign rev_time_ms    = rev_ms_q;

	// first edge never reaches stage two
	a_first_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire1 && !have_prev_q |=> !v2_q)
		else $error("first edge produced a result");

	// count parity follows the pin level of the same edge
	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> sc_s2.cnt[0] == $past(lvl_s1))
		else $error("pulse count parity mismatch");

	// window time is zero whenever it is not meaningful
	a_rev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rev_valid_q |-> rev_ms_q == '0)
		else $error("rev time nonzero without rev valid");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// testbench for the hall edge period meter: directed and random edges checked against a predictor
`timescale 1ns / 1ps

module tb_top;

	localparam int WINDOW = 8;
	localparam logic [hepm_pkg::TS_W-1:0] TENTH_MS_US = 32'd100;
	localparam logic [hepm_pkg::TS_W-1:0] MS_US = 32'd1000;
	localparam int TAIL_CYCLES = 20;

	typedef struct {
		logic [hepm_pkg::RES_W-1:0] delta;
		logic [hepm_pkg::CNT_W-1:0] count;
		logic                       rev_ok;
		logic [hepm_pkg::RES_W-1:0] rev_ms;
	} edge_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [hepm_pkg::TS_W-1:0] timestamp_us = '0;
	logic pin_level = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [hepm_pkg::RES_W-1:0] delta_tenth_ms;
	logic [hepm_pkg::CNT_W-1:0] pulse_count;
	logic rev_valid;
	logic [hepm_pkg::RES_W-1:0] rev_time_ms;

	// predictor state
	logic seen_first = 1'b0;
	logic [hepm_pkg::TS_W-1:0] prev_stamp = '0;
	logic [hepm_pkg::CNT_W-1:0] edge_tally = hepm_pkg::CNT_RESET;
	logic [hepm_pkg::TS_W-1:0] interval_hist [WINDOW] = '{default: '0};
	int hist_pos = 0;
	logic [hepm_pkg::TS_W-1:0] interval_sum = '0;

	edge_result_t pending_results[$];
	logic [hepm_pkg::TS_W-1:0] sent_ts = '0;
	logic sent_lvl = 1'b0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int errors = 0;
	int edges_sent = 0;
	int results_checked = 0;
	int rev_seen = 0;
	int sat_seen = 0;

	hall_edge_period_meter #(.WINDOW_DEPTH(WINDOW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.timestamp_us(timestamp_us),
		.pin_level(pin_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.delta_tenth_ms(delta_tenth_ms),
		.pulse_count(pulse_count),
		.rev_valid(rev_valid),
		.rev_time_ms(rev_time_ms)
	);

	always #5 clk = ~clk;

	initial begin
		#5000000;
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic logic [hepm_pkg::RES_W-1:0] clamp16(
		input logic [hepm_pkg::TS_W-1:0] v);
		return (v > hepm_pkg::TS_W'(hepm_pkg::RES_SAT)) ? hepm_pkg::RES_SAT
			: v[hepm_pkg::RES_W-1:0];
	endfunction

	task automatic predict_edge(input logic [hepm_pkg::TS_W-1:0] ts, input logic lvl);
		logic [hepm_pkg::TS_W-1:0] dt;
		logic [hepm_pkg::TS_W-1:0] old;
		logic [hepm_pkg::CNT_W-1:0] cnt;
		edge_result_t r;
		if (!seen_first) begin
			seen_first = 1'b1;
			prev_stamp = ts;
			return;
		end
		dt = ts - prev_stamp;
		prev_stamp = ts;
		cnt = edge_tally + 1'b1;
		if (cnt[0] != lvl) begin
			cnt = cnt + 1'b1;
		end
		edge_tally = cnt;
		old = interval_hist[hist_pos];
		interval_sum = interval_sum - old + dt;
		interval_hist[hist_pos] = dt;
		hist_pos = (hist_pos == WINDOW - 1) ? 0 : hist_pos + 1;
		r.delta = clamp16(dt / TENTH_MS_US);
		r.count = cnt;
		r.rev_ok = (old != '0);
		r.rev_ms = r.rev_ok ? clamp16(interval_sum / MS_US) : '0;
		pending_results.push_back(r);
	endtask

	// one transaction; starts and ends at a falling edge
	task automatic send_edge(input logic [hepm_pkg::TS_W-1:0] ts, input logic lvl);
		int gap;
		gap = 0;
		while ($urandom_range(99) < snd_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		timestamp_us <= ts;
		pin_level <= lvl;
		do @(posedge clk); while (!in_ready);
		predict_edge(ts, lvl);
		sent_ts = ts;
		sent_lvl = lvl;
		edges_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic check_field(input string name, input logic [hepm_pkg::TS_W-1:0] want,
		input logic [hepm_pkg::TS_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin : result_check
		edge_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual delta %0d count %0d",
					$time, delta_tenth_ms, pulse_count);
			end else begin
				want = pending_results.pop_front();
				check_field("delta_tenth_ms", hepm_pkg::TS_W'(want.delta),
					hepm_pkg::TS_W'(delta_tenth_ms));
				check_field("pulse_count", hepm_pkg::TS_W'(want.count),
					hepm_pkg::TS_W'(pulse_count));
				check_field("rev_valid", hepm_pkg::TS_W'(want.rev_ok),
					hepm_pkg::TS_W'(rev_valid));
				check_field("rev_time_ms", hepm_pkg::TS_W'(want.rev_ms),
					hepm_pkg::TS_W'(rev_time_ms));
				results_checked++;
				if (want.rev_ok) begin
					rev_seen++;
				end
				if (want.delta == hepm_pkg::RES_SAT || want.rev_ms == hepm_pkg::RES_SAT) begin
					sat_seen++;
				end
			end
		end
	end

	// first edge gives nothing, zero timestamp and zero interval count as real
	task automatic test_first_edge();
		send_edge(32'd0, 1'b1);
		send_edge(32'd0, 1'b0);
		send_edge(sent_ts + 32'd99, 1'b1);
		send_edge(sent_ts + 32'd100, 1'b1);
	endtask

	task automatic test_pulse_parity();
		send_edge(sent_ts + 32'd2500, 1'b0);
		send_edge(sent_ts + 32'd2500, 1'b0);
		send_edge(sent_ts + 32'd2500, 1'b1);
		send_edge(sent_ts + 32'd2500, 1'b0);
	endtask

	task automatic test_timestamp_wrap();
		send_edge(32'hFFFF_FF00, 1'b1);
		send_edge(32'h0000_0100, 1'b0);
		send_edge(32'hFFFF_FFFF, 1'b1);
	endtask

	// interval boundaries, window sum wrap and revolution time saturation
	task automatic test_saturation();
		send_edge(sent_ts + 32'd6553499, 1'b0);
		send_edge(sent_ts + 32'd6553500, 1'b1);
		send_edge(sent_ts + 32'd6553600, 1'b0);
		send_edge(sent_ts + 32'hFFFF_FFFF, 1'b1);
		repeat (3) send_edge(sent_ts + 32'h8000_0000, ~sent_lvl);
		repeat (3) send_edge(sent_ts + 32'd20000000, ~sent_lvl);
	endtask

	task automatic test_random(input int n, input int snd_pct, input int rcv_pct);
		int pick;
		logic [hepm_pkg::TS_W-1:0] dt;
		logic [hepm_pkg::TS_W-1:0] ts;
		logic lvl;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 5) dt = '0;
			else if (pick < 15) dt = $urandom_range(199);
			else if (pick < 60) dt = $urandom_range(200000, 1000);
			else if (pick < 75) dt = $urandom_range(12000000, 200000);
			else if (pick < 85) dt = $urandom_range(6554000, 6553000);
			else dt = $urandom;
			ts = (pick >= 93) ? $urandom : sent_ts + dt;
			lvl = ($urandom_range(3) == 0) ? 1'($urandom) : ~sent_lvl;
			send_edge(ts, lvl);
			if (i == n / 2) begin
				wait_drain();
			end
		end
		wait_drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_first_edge();
		test_pulse_parity();
		test_timestamp_wrap();
		test_saturation();
		wait_drain();
		test_random(233, 10, 51);
		test_random(233, 51, 10);
		test_random(234, 0, 0);
		rcv_idle_pct = 0;
		wait_drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("edges sent %0d, results checked %0d", edges_sent, results_checked);
		$display("with revolution time %0d, with a saturated field %0d", rev_seen, sat_seen);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
